// ===== rtl/assert_macros.svh =====
// Assertion macros for the heap allocator RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted (active-low reset).
`define NFZHA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define NFZHA_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/nfzha_pkg.sv =====
// Package for the next-fit zone heap allocator: sizes, codes, types, helpers.
// No dependencies.
`timescale 1ns / 1ps

package nfzha_pkg;

  localparam int MAIN_UNITS   = 4096;
  localparam int SMALL_UNITS  = 1024;
  localparam int UNIT_BYTES   = 8;
  localparam int UNIT_SHIFT   = 3;
  localparam int HEADER_BYTES = 32;
  localparam int ALL_UNITS    = MAIN_UNITS + SMALL_UNITS;
  localparam int DEPTH        = ALL_UNITS + 2;
  localparam int MAIN_SENT    = ALL_UNITS;
  localparam int SMALL_SENT   = ALL_UNITS + 1;
  localparam int IDX_W        = 13;
  localparam int SIZE_W       = 13;
  localparam int HDR_MIN      = ((HEADER_BYTES + UNIT_BYTES - 1) / UNIT_BYTES) * UNIT_BYTES;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [SIZE_W-1:0] size_t;

  localparam logic [2:0] TAG_UNOWNED = 3'd0;
  localparam logic [2:0] TAG_GEN     = 3'd1;
  localparam logic [2:0] TAG_MINOR   = 3'd2;
  localparam logic [2:0] TAG_PINNED  = 3'd3;

  localparam logic [1:0] OP_ALLOC     = 2'd0;
  localparam logic [1:0] OP_FREE      = 2'd1;
  localparam logic [1:0] OP_FREE_TAGS = 2'd2;

  localparam logic [2:0] STS_OK         = 3'd0;
  localparam logic [2:0] STS_NO_MEM     = 3'd1;
  localparam logic [2:0] STS_NULL       = 3'd2;
  localparam logic [2:0] STS_NOT_BLOCK  = 3'd3;
  localparam logic [2:0] STS_DOUBLE     = 3'd4;
  localparam logic [2:0] STS_FREE_TAG   = 3'd5;
  localparam logic [2:0] STS_STATIC_TAG = 3'd6;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] request_bytes;
    logic [2:0]  block_tag;
    logic [15:0] payload_address;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] result_address;
    logic [12:0] freed_count;
    logic [15:0] main_available_bytes;
  } out_item_t;

  // One block-table entry.
  typedef struct packed {
    logic       hdr;
    logic [2:0] tag;
    size_t      size;
    idx_t       prev;
    idx_t       next;
  } ent_t;

  typedef struct packed {
    logic [SIZE_W:0] a;
    logic [SIZE_W:0] b;
    logic            sub;
  } alu_req_t;

  typedef struct packed {
    logic [SIZE_W:0] res;
    logic            ge;
  } alu_rsp_t;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_DEC,
    S_A_START, S_A_LOOP, S_A_E, S_A_B, S_A_SPL, S_A_WF, S_A_WNX, S_A_WB,
    S_F_B,
    S_FT_SD, S_FT_L, S_FT_E, S_FT_NX,
    S_RL_0, S_RL_P, S_RL_N, S_RL_NN, S_RL_WC,
    S_DONE
  } state_t;

  function automatic idx_t fix_idx(input idx_t i);
    return (i < idx_t'(DEPTH)) ? i : '0;
  endfunction

  // Table contents after reset.
  function automatic ent_t clr_entry(input idx_t i);
    ent_t e;
    e = '0;
    if (i == idx_t'(0)) begin
      e.hdr = 1'b1; e.tag = TAG_UNOWNED; e.size = size_t'(MAIN_UNITS);
      e.prev = idx_t'(MAIN_SENT); e.next = idx_t'(MAIN_SENT);
    end else if (i == idx_t'(MAIN_UNITS)) begin
      e.hdr = 1'b1; e.tag = TAG_UNOWNED; e.size = size_t'(SMALL_UNITS);
      e.prev = idx_t'(SMALL_SENT); e.next = idx_t'(SMALL_SENT);
    end else if (i == idx_t'(MAIN_SENT)) begin
      e.tag = TAG_GEN; e.prev = idx_t'(0); e.next = idx_t'(0);
    end else if (i == idx_t'(SMALL_SENT)) begin
      e.tag = TAG_GEN; e.prev = idx_t'(MAIN_UNITS); e.next = idx_t'(MAIN_UNITS);
    end
    return e;
  endfunction

endpackage

// ===== rtl/nfzha_ram.sv =====
// Block table memory: one write port, one read port with registered data.
// Depends on nfzha_pkg.
`timescale 1ns / 1ps

module nfzha_ram (
  input  logic            clk,
  input  logic            we,
  input  nfzha_pkg::idx_t waddr,
  input  nfzha_pkg::ent_t wdata,
  input  nfzha_pkg::idx_t raddr,
  output nfzha_pkg::ent_t rdata
);
  import nfzha_pkg::*;

  ent_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/nfzha_alu.sv =====
// Shared add/subtract and compare unit used by the sequencer.
// Depends on nfzha_pkg.
`timescale 1ns / 1ps

module nfzha_alu (
  input  nfzha_pkg::alu_req_t req,
  output nfzha_pkg::alu_rsp_t rsp
);
  import nfzha_pkg::*;

  logic [SIZE_W+1:0] wide;

  always_comb begin
    if (req.sub) begin
      wide = {1'b0, req.a} - {1'b0, req.b};
    end else begin
      wide = {1'b0, req.a} + {1'b0, req.b};
    end
    rsp.res = wide[SIZE_W:0];
    rsp.ge  = req.sub & ~wide[SIZE_W+1];
  end

endmodule

// ===== rtl/next_fit_zone_heap_allocator.sv =====
// Next-fit heap allocator over a main and a small zone. After reset the block table is
// swept entry by entry with in_stall high; configuration writes are taken throughout.
// One beat is worked at a time: allocate walks the blocks from the rover for a fit and
// writes back, splitting off a large enough remainder; free reads the block and, unless
// refused or static, releases it and merges it with unowned neighbours; free-tags walks
// the zone ring and releases blocks with the given tag. The work is paced by the
// single-read-port block table, one registered read per step, and by the shared adder.
// Results leave through an output register.
`timescale 1ns / 1ps

module next_fit_zone_heap_allocator (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  nfzha_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output nfzha_pkg::out_item_t out_data,
  input  logic                 cfg_we,
  input  logic [12:0]          cfg_wdata
);
  import nfzha_pkg::*;
  `include "assert_macros.svh"

  state_t state_r, state_nxt;

  idx_t        clr_idx_r;
  logic [12:0] min_frag_r;
  in_item_t    item_r;
  logic [SIZE_W:0] need_r;
  idx_t        rover_main_r, rover_small_r;
  size_t       used_main_r, used_small_r;
  idx_t        rv_r, base_r, start_r, f_r, b_r, cidx_r, nn_r, sent_r;
  ent_t        base_e_r, be_r, cur_r;
  size_t       extra_r;
  logic        split_r, m1_r, small_r, tz_r;
  logic [12:0] cnt_r;
  logic [2:0]  status_r;
  logic [15:0] res_addr_r;
  logic        out_valid_r;
  out_item_t   out_data_r;

  logic     mem_we;
  idx_t     mem_waddr, mem_raddr;
  ent_t     mem_wdata, rd;
  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  nfzha_ram u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rd)
  );

  nfzha_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // Decode of the held item
  logic        a_small;
  logic [15:0] f_off;
  idx_t        f_blk;
  logic        f_null, f_bad;
  logic [12:0] minf;
  ent_t        wb_ent;
  logic        fit_e, fit_b, do_split;
  logic [SIZE_W+3:0] need_sum;

  always_comb begin
    a_small  = item_r.block_tag == TAG_MINOR;
    f_off    = item_r.payload_address - 16'(HEADER_BYTES);
    f_blk    = f_off[UNIT_SHIFT+IDX_W-1:UNIT_SHIFT];
    f_null   = item_r.payload_address == 16'd0;
    f_bad    = (item_r.payload_address < 16'(HEADER_BYTES)) ||
               (f_off[UNIT_SHIFT-1:0] != '0) ||
               (f_off[15:UNIT_SHIFT] >= 13'(ALL_UNITS));
    minf     = (min_frag_r < 13'(HDR_MIN)) ? 13'(HDR_MIN) : min_frag_r;
    fit_e    = (base_e_r.tag == TAG_UNOWNED) && alu_rsp.ge;
    fit_b    = (rd.tag == TAG_UNOWNED) && alu_rsp.ge;
    do_split = (alu_rsp.res < (SIZE_W+1)'(DEPTH)) &&
               ({extra_r, 3'b000} >= {3'b000, minf});
    wb_ent     = base_e_r;
    wb_ent.hdr = 1'b1;
    wb_ent.tag = item_r.block_tag;
    if (split_r) begin
      wb_ent.size = need_r[SIZE_W-1:0];
      wb_ent.next = f_r;
    end
    need_sum = {1'b0, in_data.request_bytes} + 17'(HEADER_BYTES + UNIT_BYTES - 1);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:     if (clr_idx_r == idx_t'(DEPTH - 1)) state_nxt = S_IDLE;
      S_IDLE:    if (in_valid) state_nxt = S_DEC;
      S_DEC: begin
        priority case (item_r.opcode)
          OP_ALLOC:
            state_nxt = (item_r.block_tag == TAG_UNOWNED) ? S_DONE : S_A_START;
          OP_FREE:
            state_nxt = (f_null || f_bad) ? S_DONE : S_F_B;
          OP_FREE_TAGS:
            state_nxt = (item_r.block_tag == TAG_PINNED) ? S_DONE : S_FT_SD;
          default:
            state_nxt = S_DONE;
        endcase
      end
      S_A_START: state_nxt = S_A_LOOP;
      S_A_LOOP:  state_nxt = (rv_r == start_r) ? S_DONE : S_A_E;
      S_A_E: begin
        if (rd.tag != TAG_UNOWNED) state_nxt = S_A_B;
        else if (fit_e)            state_nxt = S_A_SPL;
        else                       state_nxt = S_A_LOOP;
      end
      S_A_B:     state_nxt = fit_b ? S_A_SPL : S_A_LOOP;
      S_A_SPL:   state_nxt = do_split ? S_A_WF : S_A_WB;
      S_A_WF:    state_nxt = S_A_WNX;
      S_A_WNX:   state_nxt = S_A_WB;
      S_A_WB:    state_nxt = S_DONE;
      S_F_B: begin
        if (!rd.hdr || rd.tag == TAG_UNOWNED || rd.tag == TAG_PINNED) state_nxt = S_DONE;
        else state_nxt = S_RL_0;
      end
      S_FT_SD:   state_nxt = S_FT_L;
      S_FT_L:    state_nxt = (b_r == sent_r) ? S_DONE : S_FT_E;
      S_FT_E: begin
        if (tz_r) state_nxt = (rd.tag == TAG_UNOWNED) ? S_DONE : S_FT_L;
        else if (rd.tag == item_r.block_tag && rd.hdr) state_nxt = S_RL_0;
        else state_nxt = S_FT_NX;
      end
      S_FT_NX:   state_nxt = (cur_r.next == sent_r) ? S_DONE : S_FT_L;
      S_RL_0:    state_nxt = S_RL_P;
      S_RL_P:    state_nxt = S_RL_N;
      S_RL_N:    state_nxt = (rd.tag == TAG_UNOWNED) ? S_RL_NN : S_RL_WC;
      S_RL_NN:   state_nxt = S_RL_WC;
      S_RL_WC:   state_nxt = (item_r.opcode == OP_FREE) ? S_DONE : S_FT_NX;
      S_DONE:    if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Memory and adder controls
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_raddr = '0;
    alu_req   = '0;
    unique case (state_r)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx_r;
        mem_wdata = clr_entry(clr_idx_r);
      end
      S_DEC: begin
        priority case (item_r.opcode)
          OP_ALLOC:     mem_raddr = fix_idx(a_small ? rover_small_r : rover_main_r);
          OP_FREE:      mem_raddr = f_blk;
          OP_FREE_TAGS: mem_raddr = a_small ? idx_t'(SMALL_SENT) : idx_t'(MAIN_SENT);
          default:      mem_raddr = '0;
        endcase
      end
      S_A_LOOP: mem_raddr = rv_r;
      S_A_E: begin
        mem_raddr = fix_idx(rd.next);
        alu_req   = '{a: {1'b0, base_e_r.size}, b: need_r, sub: 1'b1};
      end
      S_A_B: alu_req = '{a: {1'b0, rd.size}, b: need_r, sub: 1'b1};
      S_A_SPL: alu_req = '{a: {1'b0, base_r}, b: need_r, sub: 1'b0};
      S_A_WF: begin
        mem_we    = 1'b1;
        mem_waddr = f_r;
        mem_wdata = '{hdr: 1'b1, tag: TAG_UNOWNED, size: extra_r, prev: base_r,
                      next: fix_idx(base_e_r.next)};
        mem_raddr = fix_idx(base_e_r.next);
      end
      S_A_WNX: begin
        mem_we         = 1'b1;
        mem_waddr      = fix_idx(base_e_r.next);
        mem_wdata      = rd;
        mem_wdata.prev = f_r;
      end
      S_A_WB: begin
        mem_we    = 1'b1;
        mem_waddr = base_r;
        mem_wdata = wb_ent;
        alu_req   = '{a: {1'b0, a_small ? used_small_r : used_main_r},
                      b: {1'b0, wb_ent.size}, sub: 1'b0};
      end
      S_FT_L: mem_raddr = b_r;
      S_RL_0: begin
        mem_we        = 1'b1;
        mem_waddr     = b_r;
        mem_wdata     = be_r;
        mem_wdata.tag = TAG_UNOWNED;
        mem_raddr     = fix_idx(be_r.prev);
        alu_req       = '{a: {1'b0, (b_r >= idx_t'(MAIN_UNITS)) ? used_small_r : used_main_r},
                          b: {1'b0, be_r.size}, sub: 1'b1};
      end
      S_RL_P: begin
        mem_raddr = fix_idx(be_r.next);
        alu_req   = '{a: {1'b0, cur_r.size}, b: {1'b0, rd.size}, sub: 1'b0};
      end
      S_RL_N: begin
        mem_we         = m1_r;
        mem_waddr      = fix_idx(be_r.next);
        mem_wdata      = rd;
        mem_wdata.prev = cidx_r;
        mem_raddr      = fix_idx(rd.next);
        alu_req        = '{a: {1'b0, cur_r.size}, b: {1'b0, rd.size}, sub: 1'b0};
      end
      S_RL_NN: begin
        mem_we         = 1'b1;
        mem_waddr      = nn_r;
        mem_wdata      = rd;
        mem_wdata.prev = cidx_r;
      end
      S_RL_WC: begin
        mem_we    = 1'b1;
        mem_waddr = cidx_r;
        mem_wdata = cur_r;
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLR;
      clr_idx_r     <= '0;
      min_frag_r    <= 13'd64;
      rover_main_r  <= '0;
      rover_small_r <= idx_t'(MAIN_UNITS);
      used_main_r   <= '0;
      used_small_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        min_frag_r <= cfg_wdata;
      end
      if (state_r == S_CLR) begin
        clr_idx_r <= clr_idx_r + idx_t'(1);
      end
      if (state_r == S_A_WB) begin
        if (a_small) begin
          rover_small_r <= fix_idx(wb_ent.next);
          used_small_r  <= alu_rsp.res[SIZE_W-1:0];
        end else begin
          rover_main_r <= fix_idx(wb_ent.next);
          used_main_r  <= alu_rsp.res[SIZE_W-1:0];
        end
      end
      if (state_r == S_RL_0) begin
        if (b_r >= idx_t'(MAIN_UNITS)) used_small_r <= alu_rsp.res[SIZE_W-1:0];
        else                           used_main_r  <= alu_rsp.res[SIZE_W-1:0];
      end
      if (state_r == S_RL_N) begin
        if (small_r) rover_small_r <= cidx_r;
        else         rover_main_r  <= cidx_r;
      end
      if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        item_r <= in_data;
        need_r <= need_sum[SIZE_W+3:UNIT_SHIFT];
      end
      S_DEC: begin
        status_r   <= STS_OK;
        res_addr_r <= '0;
        cnt_r      <= '0;
        rv_r       <= fix_idx(a_small ? rover_small_r : rover_main_r);
        base_r     <= fix_idx(a_small ? rover_small_r : rover_main_r);
        sent_r     <= a_small ? idx_t'(SMALL_SENT) : idx_t'(MAIN_SENT);
        tz_r       <= item_r.block_tag == TAG_UNOWNED;
        b_r        <= f_blk;
        priority case (item_r.opcode)
          OP_ALLOC:
            if (item_r.block_tag == TAG_UNOWNED) status_r <= STS_FREE_TAG;
          OP_FREE:
            if (f_null)     status_r <= STS_NULL;
            else if (f_bad) status_r <= STS_NOT_BLOCK;
          OP_FREE_TAGS:
            if (item_r.block_tag == TAG_PINNED) status_r <= STS_STATIC_TAG;
          default: begin
          end
        endcase
      end
      S_A_START: begin
        base_e_r <= rd;
        start_r  <= fix_idx(rd.prev);
      end
      S_A_LOOP:
        if (rv_r == start_r) status_r <= STS_NO_MEM;
      S_A_E: begin
        rv_r <= fix_idx(rd.next);
        if (rd.tag != TAG_UNOWNED) base_r <= fix_idx(rd.next);
        extra_r <= alu_rsp.res[SIZE_W-1:0];
      end
      S_A_B: begin
        base_e_r <= rd;
        extra_r  <= alu_rsp.res[SIZE_W-1:0];
      end
      S_A_SPL: begin
        f_r     <= alu_rsp.res[IDX_W-1:0];
        split_r <= do_split;
      end
      S_A_WB:
        res_addr_r <= 16'({base_r, 3'b000} + 16'(HEADER_BYTES));
      S_F_B: begin
        be_r <= rd;
        if (!rd.hdr)                    status_r <= STS_NOT_BLOCK;
        else if (rd.tag == TAG_UNOWNED) status_r <= STS_DOUBLE;
      end
      S_FT_SD:
        b_r <= fix_idx(rd.next);
      S_FT_E: begin
        be_r  <= rd;
        cur_r <= rd;
        if (tz_r) begin
          b_r <= fix_idx(rd.next);
          if (rd.tag == TAG_UNOWNED) status_r <= STS_DOUBLE;
        end
      end
      S_FT_NX:
        b_r <= fix_idx(cur_r.next);
      S_RL_0: begin
        cur_r   <= '{hdr: be_r.hdr, tag: TAG_UNOWNED, size: be_r.size,
                     prev: be_r.prev, next: be_r.next};
        cidx_r  <= b_r;
        m1_r    <= 1'b0;
        small_r <= b_r >= idx_t'(MAIN_UNITS);
      end
      S_RL_P:
        if (rd.tag == TAG_UNOWNED) begin
          cur_r  <= '{hdr: rd.hdr, tag: rd.tag, size: alu_rsp.res[SIZE_W-1:0],
                      prev: rd.prev, next: fix_idx(be_r.next)};
          cidx_r <= fix_idx(be_r.prev);
          m1_r   <= 1'b1;
        end
      S_RL_N: begin
        nn_r <= fix_idx(rd.next);
        if (rd.tag == TAG_UNOWNED) begin
          cur_r <= '{hdr: cur_r.hdr, tag: cur_r.tag, size: alu_rsp.res[SIZE_W-1:0],
                     prev: cur_r.prev, next: fix_idx(rd.next)};
        end
      end
      S_RL_WC:
        if (item_r.opcode != OP_FREE) cnt_r <= cnt_r + 13'd1;
      S_DONE:
        if (!out_valid_r || !out_stall) begin
          out_data_r <= '{status: status_r, result_address: res_addr_r,
                          freed_count: cnt_r,
                          main_available_bytes: 16'(MAIN_UNITS * UNIT_BYTES) -
                                                {used_main_r, 3'b000}};
        end
      default: begin
      end
    endcase
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `NFZHA_ASSERT(a_out_from_done, clk, rst_n, $rose(out_valid_r) |-> $past(state_r == S_DONE), "result beat raised outside completion")
  `NFZHA_ASSERT(a_used_bounded, clk, rst_n, (state_r == S_IDLE) |-> (used_main_r <= size_t'(MAIN_UNITS) && used_small_r <= size_t'(SMALL_UNITS)), "zone usage out of range")
  `NFZHA_ASSERT(a_idle_no_write, clk, rst_n, (state_r == S_IDLE) |-> !mem_we, "block table written while idle")

endmodule
